// ----- design/tcsx_pkg.sv -----
// ----------------------------------------------------------------------------
// tcsx_pkg
// shared types and constants of the client hello server-name extractor
// ----------------------------------------------------------------------------
package tcsx_pkg;

   localparam logic [1:0] CMD_FEED    = 2'd0;
   localparam logic [1:0] CMD_RESTART = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;
   localparam logic [1:0] CMD_NOP     = 2'd3;

   typedef enum logic [1:0] {
      VERDICT_NEED  = 2'd0,
      VERDICT_FOUND = 2'd1,
      VERDICT_UNSUP = 2'd2
   } verdict_type;

   typedef enum logic [11:0] {
      PH_TYPE   = 12'b0000_0000_0001,
      PH_LEN    = 12'b0000_0000_0010,
      PH_VER    = 12'b0000_0000_0100,
      PH_RANDOM = 12'b0000_0000_1000,
      PH_SIDLEN = 12'b0000_0001_0000,
      PH_SID    = 12'b0000_0010_0000,
      PH_CSLEN  = 12'b0000_0100_0000,
      PH_CS     = 12'b0000_1000_0000,
      PH_CMLEN  = 12'b0001_0000_0000,
      PH_CM     = 12'b0010_0000_0000,
      PH_EXTLEN = 12'b0100_0000_0000,
      PH_EXT    = 12'b1000_0000_0000
   } phase_type;

   localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'd22;
   localparam logic [7:0]  HELLO_TYPE_CLIENT  = 8'd1;
   localparam logic [15:0] VERSION_LO         = 16'h0301;
   localparam logic [15:0] VERSION_MID        = 16'h0302;
   localparam logic [15:0] VERSION_HI         = 16'h0303;
   localparam logic [15:0] RECORD_MAX_LEN     = 16'h4000;
   localparam logic [23:0] HELLO_MAX_LEN      = 24'h010000;
   localparam logic [7:0]  SESSION_ID_MAX     = 8'd32;

   // store write request from the parser
   typedef struct packed {
      logic       en;
      logic [9:0] addr;
      logic [7:0] data;
   } store_wr_type;

   function automatic logic version_ok(input logic [15:0] v);
      return (v == VERSION_LO) || (v == VERSION_MID) || (v == VERSION_HI);
   endfunction

endpackage

// ----- design/tcsx_parser.sv -----
// ----------------------------------------------------------------------------
// tcsx_parser
// record and client hello parser state, one stream byte per transfer
// ----------------------------------------------------------------------------
module tcsx_parser #(
   parameter int NAME_BUFFER_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [1:0]             cmd,
   input  logic [7:0]             data_byte,
   output tcsx_pkg::verdict_type  verdict,
   output logic [15:0]            name_length,
   output logic                   name_truncated,
   output tcsx_pkg::store_wr_type store_wr
);
   import tcsx_pkg::*;

   localparam logic [16:0] STORE_LIMIT = 17'(NAME_BUFFER_BYTES - 1);
   localparam logic [15:0] TRUNC_LIMIT = 16'(NAME_BUFFER_BYTES);

   verdict_type verdict_ff, verdict_in;
   logic [2:0]  rhc_ff, rhc_in;
   logic [15:0] rver_ff, rver_in, fver_ff, fver_in;
   logic [15:0] rleft_ff, rleft_in;
   phase_type   ph_ff, ph_in;
   logic [16:0] hoff_ff, hoff_in;
   logic [23:0] hlen_ff, hlen_in;
   logic [15:0] hver_ff, hver_in;
   logic [16:0] send_ff, send_in;
   logic [15:0] lfs_ff, lfs_in;
   logic [16:0] epos_ff, epos_in;
   logic [15:0] etype_ff, etype_in, elen_ff, elen_in, elist_ff, elist_in;
   logic [16:0] npos_ff, npos_in;
   logic [7:0]  ntype_ff, ntype_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [15:0] fnl_ff, fnl_in;
   logic        trunc_ff, trunc_in;

   always_comb begin
      logic [7:0]  b;
      logic [16:0] off1, d, i;
      logic [15:0] v16, rl;
      logic [23:0] hl;
      logic        hit;
      b = data_byte;
      verdict_in = verdict_ff; rhc_in = rhc_ff; rver_in = rver_ff; fver_in = fver_ff;
      rleft_in = rleft_ff; ph_in = ph_ff; hoff_in = hoff_ff; hlen_in = hlen_ff;
      hver_in = hver_ff; send_in = send_ff; lfs_in = lfs_ff; epos_in = epos_ff;
      etype_in = etype_ff; elen_in = elen_ff; elist_in = elist_ff; npos_in = npos_ff;
      ntype_in = ntype_ff; nlen_in = nlen_ff; fnl_in = fnl_ff; trunc_in = trunc_ff;
      store_wr = '0;
      off1 = hoff_ff + 17'd1;
      d = epos_ff - 17'd4;
      i = npos_ff - 17'd3;
      v16 = '0; rl = '0; hl = '0; hit = 1'b0;
      if (step && cmd == CMD_RESTART) begin
         verdict_in = VERDICT_NEED; rhc_in = '0; rver_in = '0; fver_in = '0;
         rleft_in = '0; ph_in = PH_TYPE; hoff_in = '0; hlen_in = '0; hver_in = '0;
         send_in = '0; lfs_in = '0; epos_in = '0; etype_in = '0; elen_in = '0;
         elist_in = '0; npos_in = '0; ntype_in = '0; nlen_in = '0;
         fnl_in = '0; trunc_in = 1'b0;
      end else if (step && cmd == CMD_FEED && verdict_ff == VERDICT_NEED) begin
         if (rhc_ff < 3'd5) begin
            if (rhc_ff == 3'd0) begin
               if (b != REC_TYPE_HANDSHAKE) verdict_in = VERDICT_UNSUP;
               else rhc_in = 3'd1;
            end else if (rhc_ff <= 3'd2) begin
               v16 = {rver_ff[7:0], b};
               rver_in = v16;
               if (rhc_ff == 3'd2 && (!version_ok(v16) ||
                   (fver_ff != '0 && fver_ff != v16))) begin
                  verdict_in = VERDICT_UNSUP;
               end else begin
                  if (rhc_ff == 3'd2) fver_in = v16;
                  rhc_in = rhc_ff + 3'd1;
               end
            end else begin
               rl = {rleft_ff[7:0], b};
               rleft_in = rl;
               if (rhc_ff == 3'd4 && rl > RECORD_MAX_LEN) begin
                  verdict_in = VERDICT_UNSUP;
               end else if (rhc_ff == 3'd4 && rl == '0) begin
                  rhc_in = '0; rver_in = '0;
               end else begin
                  rhc_in = rhc_ff + 3'd1;
               end
            end
         end else begin
            // hello byte
            if (ph_ff == PH_TYPE) begin
               if (b != HELLO_TYPE_CLIENT) verdict_in = VERDICT_UNSUP;
               else begin hoff_in = 17'd1; ph_in = PH_LEN; end
            end else if (ph_ff == PH_LEN) begin
               hl = {hlen_ff[15:0], b};
               hlen_in = hl; hoff_in = off1;
               if (off1 == 17'd4) begin
                  if (hl > HELLO_MAX_LEN) verdict_in = VERDICT_UNSUP;
                  else ph_in = PH_VER;
               end
            end else if (ph_ff == PH_RANDOM) begin
               hoff_in = off1;
               if (off1 == 17'd38) begin
                  ph_in = PH_SIDLEN; send_in = off1 + 17'd1; lfs_in = '0;
               end
            end else if ({7'd0, hoff_ff} >= hlen_ff + 24'd4) begin
               verdict_in = VERDICT_UNSUP;
            end else begin
               hoff_in = off1;
               case (ph_ff)
                  PH_VER: begin
                     v16 = {hver_ff[7:0], b};
                     hver_in = v16;
                     if (off1 == 17'd6) begin
                        if (!version_ok(v16)) verdict_in = VERDICT_UNSUP;
                        else ph_in = PH_RANDOM;
                     end
                  end
                  PH_SIDLEN: begin
                     if (b > SESSION_ID_MAX) verdict_in = VERDICT_UNSUP;
                     else if (b == '0) begin
                        ph_in = PH_CSLEN; send_in = off1 + 17'd2; lfs_in = '0;
                     end else begin
                        ph_in = PH_SID; send_in = off1 + {9'd0, b};
                     end
                  end
                  PH_SID: begin
                     if (off1 == send_ff) begin
                        ph_in = PH_CSLEN; send_in = off1 + 17'd2; lfs_in = '0;
                     end
                  end
                  PH_CSLEN: begin
                     v16 = {lfs_ff[7:0], b};
                     lfs_in = v16;
                     if (off1 == send_ff) begin
                        if (v16 == '0) begin
                           ph_in = PH_CMLEN; send_in = off1 + 17'd1; lfs_in = '0;
                        end else begin
                           ph_in = PH_CS; send_in = off1 + {1'b0, v16};
                        end
                     end
                  end
                  PH_CS: begin
                     if (off1 == send_ff) begin
                        ph_in = PH_CMLEN; send_in = off1 + 17'd1; lfs_in = '0;
                     end
                  end
                  PH_CMLEN: begin
                     if (b == '0) begin
                        ph_in = PH_EXTLEN; send_in = off1 + 17'd2; lfs_in = '0;
                     end else begin
                        ph_in = PH_CM; send_in = off1 + {9'd0, b};
                     end
                  end
                  PH_CM: begin
                     if (off1 == send_ff) begin
                        ph_in = PH_EXTLEN; send_in = off1 + 17'd2; lfs_in = '0;
                     end
                  end
                  PH_EXTLEN: begin
                     v16 = {lfs_ff[7:0], b};
                     lfs_in = v16;
                     if (off1 == send_ff) begin
                        send_in = off1 + {1'b0, v16};
                        ph_in = PH_EXT;
                        if (v16 == '0) verdict_in = VERDICT_UNSUP;
                     end
                  end
                  PH_EXT: begin
                     // extension walk
                     if (epos_ff < 17'd2) begin
                        etype_in = {etype_ff[7:0], b}; epos_in = epos_ff + 17'd1;
                     end else if (epos_ff < 17'd4) begin
                        v16 = {elen_ff[7:0], b};
                        elen_in = v16; epos_in = epos_ff + 17'd1;
                        if (epos_ff == 17'd3 && v16 == '0) begin
                           epos_in = '0; etype_in = '0; elen_in = '0; elist_in = '0;
                           npos_in = '0; ntype_in = '0; nlen_in = '0;
                        end
                     end else begin
                        epos_in = epos_ff + 17'd1;
                        if (etype_ff == '0) begin
                           if (d < 17'd2) elist_in = {elist_ff[7:0], b};
                           else if (d < {1'b0, elist_ff} + 17'd2) begin
                              if (npos_ff == '0) begin
                                 ntype_in = b; npos_in = 17'd1;
                              end else if (npos_ff < 17'd3) begin
                                 v16 = {nlen_ff[7:0], b};
                                 nlen_in = v16; npos_in = npos_ff + 17'd1;
                                 if (npos_ff == 17'd2 && v16 == '0) begin
                                    npos_in = '0; ntype_in = '0; nlen_in = '0;
                                 end
                              end else begin
                                 if (ntype_ff == '0 && i < STORE_LIMIT) begin
                                    store_wr.en = 1'b1;
                                    store_wr.addr = i[9:0];
                                    store_wr.data = b;
                                 end
                                 npos_in = npos_ff + 17'd1;
                                 if (i + 17'd1 == {1'b0, nlen_ff}) begin
                                    if (ntype_ff == '0) begin
                                       fnl_in = nlen_ff;
                                       trunc_in = nlen_ff >= TRUNC_LIMIT;
                                       hit = 1'b1;
                                    end
                                    npos_in = '0; ntype_in = '0; nlen_in = '0;
                                 end
                              end
                           end
                        end
                        if (!hit && epos_ff + 17'd1 == {1'b0, elen_ff} + 17'd4) begin
                           epos_in = '0; etype_in = '0; elen_in = '0; elist_in = '0;
                           npos_in = '0; ntype_in = '0; nlen_in = '0;
                        end
                     end
                     if (hit) verdict_in = VERDICT_FOUND;
                     else if (off1 == send_ff) verdict_in = VERDICT_UNSUP;
                  end
                  default: ;
               endcase
            end
            rleft_in = rleft_ff - 16'd1;
            if (rleft_ff == 16'd1) begin rhc_in = '0; rver_in = '0; end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_ff <= VERDICT_NEED; rhc_ff <= '0; rver_ff <= '0; fver_ff <= '0;
         rleft_ff <= '0; ph_ff <= PH_TYPE; hoff_ff <= '0; hlen_ff <= '0; hver_ff <= '0;
         send_ff <= '0; lfs_ff <= '0; epos_ff <= '0; etype_ff <= '0; elen_ff <= '0;
         elist_ff <= '0; npos_ff <= '0; ntype_ff <= '0; nlen_ff <= '0;
         fnl_ff <= '0; trunc_ff <= 1'b0;
      end else begin
         verdict_ff <= verdict_in; rhc_ff <= rhc_in; rver_ff <= rver_in; fver_ff <= fver_in;
         rleft_ff <= rleft_in; ph_ff <= ph_in; hoff_ff <= hoff_in; hlen_ff <= hlen_in;
         hver_ff <= hver_in; send_ff <= send_in; lfs_ff <= lfs_in; epos_ff <= epos_in;
         etype_ff <= etype_in; elen_ff <= elen_in; elist_ff <= elist_in;
         npos_ff <= npos_in; ntype_ff <= ntype_in; nlen_ff <= nlen_in;
         fnl_ff <= fnl_in; trunc_ff <= trunc_in;
      end
   end

   assign verdict        = verdict_in;
   assign name_length    = fnl_in;
   assign name_truncated = trunc_in;
endmodule

// ----- design/tcsx_name_store.sv -----
// ----------------------------------------------------------------------------
// tcsx_name_store
// host name byte memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcsx_name_store #(
   parameter int NAME_BUFFER_BYTES = 256
) (
   input  logic                   clock,
   input  tcsx_pkg::store_wr_type store_wr,
   input  logic                   rd_load,
   input  logic                   rd_en,
   input  logic [7:0]             rd_index,
   output logic [7:0]             rd_data
);
   import tcsx_pkg::*;

   localparam int AW = $clog2(NAME_BUFFER_BYTES);

   logic [7:0] mem_ff [NAME_BUFFER_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_wr.en) mem_ff[store_wr.addr[AW-1:0]] <= store_wr.data;
   end

   // read data follows the result register, held while the result waits
   always_ff @(posedge clock) begin
      if (rd_load) begin
         if (rd_en && {2'd0, rd_index} < 10'(NAME_BUFFER_BYTES - 1))
            rd_data_ff <= mem_ff[AW'({2'd0, rd_index})];
         else
            rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/tls_client_hello_sni_extractor_top.sv -----
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extractor_top
// extracts the server name from a tls client hello byte stream
// ----------------------------------------------------------------------------
//  channel  ports                                    direction
//  req      req_valid req_ready req_cmd req_data_byte in
//           req_read_index
//  rsp      rsp_valid rsp_ready rsp_verdict           out
//           rsp_name_length rsp_name_truncated rsp_read_data
//
// the parser state and the result register update in the cycle a request
// transfer happens. req_ready is high when the result register is empty or
// being taken, so items stream at one per cycle while rsp_ready holds. reset
// clears the parse state; the name memory is not cleared.
module tls_client_hello_sni_extractor_top #(
   parameter int NAME_BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_name_length,
   output logic        rsp_name_truncated,
   output logic [7:0]  rsp_read_data
);
   import tcsx_pkg::*;

   logic         step;
   verdict_type  verdict;
   logic [15:0]  name_length;
   logic         name_truncated;
   store_wr_type store_wr;
   logic         valid_ff;
   logic [1:0]   verdict_ff;
   logic [15:0]  len_ff;
   logic         trunc_ff;

   assign req_ready = !valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   tcsx_parser #(.NAME_BUFFER_BYTES(NAME_BUFFER_BYTES)) u_parser (
      .clock, .reset, .step, .cmd(req_cmd), .data_byte(req_data_byte),
      .verdict, .name_length, .name_truncated, .store_wr
   );

   tcsx_name_store #(.NAME_BUFFER_BYTES(NAME_BUFFER_BYTES)) u_store (
      .clock, .store_wr, .rd_load(step), .rd_en(req_cmd == CMD_READ),
      .rd_index(req_read_index), .rd_data(rsp_read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (req_ready) valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         verdict_ff <= verdict;
         len_ff     <= name_length;
         trunc_ff   <= name_truncated;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_name_length    = len_ff;
   assign rsp_name_truncated = trunc_ff;
endmodule
